FILE: src/selq_pkg.sv
// ----------------------------------------------------------------------------
// selq_pkg
// Shared types and constants for the severity event log queue engine.
// ----------------------------------------------------------------------------
package selq_pkg;

  localparam int SLOT_W         = 5;
  localparam int QUEUE_DEPTH    = 1 << SLOT_W;
  localparam int SIZE_W         = SLOT_W + 1;
  localparam int GET_BATCH      = 8;
  localparam int CNT_W          = 4;
  localparam int SEV_W          = 2;
  localparam int NUM_SEVERITIES = 4;
  localparam int MEM_DEPTH      = 1 << SEV_W;
  localparam int CLR_W          = 8;
  localparam int OVF_W          = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SEV_W-1:0] severity;
    logic             clear_all;
    logic [CLR_W-1:0] clear_count;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          result_status;
    logic [SLOT_W-1:0]   slot_index;
    logic [CNT_W-1:0]    record_count;
    logic                more_pending;
    logic                overflow_seen;
    logic [OVF_W-1:0]    overflow_count;
    logic                raise_interrupt;
    logic [MEM_DEPTH-1:0] pending_mask;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic              empty;
    logic [SLOT_W-1:0] cursor;
    logic              cursor_valid;
    logic              ovf_mark;
    logic [OVF_W-1:0]  ovf_total;
  } queue_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [SEV_W-1:0] addr;
  } mem_req_t;

  localparam queue_entry_t ENTRY_RESET = '{
    head: '0, tail: '0, empty: 1'b1, cursor: '0,
    cursor_valid: 1'b0, ovf_mark: 1'b0, ovf_total: '0
  };

endpackage

FILE: src/selq_state_mem.sv
// ----------------------------------------------------------------------------
// selq_state_mem
// Per-severity queue state store with a registered read; entries read as
// their reset value until first written.
// ----------------------------------------------------------------------------
module selq_state_mem import selq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mem_req_t     req,
  input  queue_entry_t wr_data,
  output queue_entry_t rd_data
);

  queue_entry_t mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] entry_valid_r;
  queue_entry_t rd_q_r;
  logic rd_v_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      rd_v_r        <= 1'b0;
    end else begin
      if (req.wr_en) begin
        entry_valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_v_r <= entry_valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : ENTRY_RESET;

endmodule

FILE: src/severity_event_log_queues.sv
// ----------------------------------------------------------------------------
// severity_event_log_queues
// Slot pointer engine for four circular event logs, one per severity.
// ----------------------------------------------------------------------------
// Each command is accepted in S_IDLE, where the read of its queue state is
// issued; the state arrives in S_RD and the command executes in S_EXEC, when
// the state is written back and the first result beat is loaded. Add, clear
// and a failed get give one beat, a get that returns slots gives one beat per
// slot, and S_EXEC and S_EMIT wait while the output is stalled. No new command
// is taken until the last beat is loaded. No clearing pass is needed after
// reset. Record contents are kept elsewhere, addressed by the slot index here.
module severity_event_log_queues import selq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EXEC, S_EMIT} state_t;

  state_t               state_r;
  in_beat_t             item_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;
  logic [MEM_DEPTH-1:0] pend_r;
  logic [SLOT_W-1:0]    cur_slot_r;
  logic [CNT_W-1:0]     k_r;
  logic [CNT_W-1:0]     n_r;

  mem_req_t     req;
  queue_entry_t ent;
  queue_entry_t ent_nxt;
  logic [MEM_DEPTH-1:0] pend_nxt;
  out_beat_t    res;
  logic         wr_need;
  logic         multi;
  logic [CNT_W-1:0] n_nxt;
  logic         slot_free;
  logic         sev_ok;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] avail;
  logic [SLOT_W-1:0] rel;
  logic         full;
  logic         emit_last;

  selq_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (ent_nxt),
    .rd_data (ent)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit_last = (k_r == n_r - CNT_W'(1));

  always_comb begin
    req.rd_en = in_valid && (state_r == S_IDLE);
    req.wr_en = (state_r == S_EXEC) && slot_free && wr_need;
    req.addr  = (state_r == S_IDLE) ? in_data.severity : item_r.severity;
  end

  always_comb begin
    ent_nxt  = ent;
    pend_nxt = pend_r;
    wr_need  = 1'b0;
    multi    = 1'b0;
    n_nxt    = '0;
    res      = '0;
    res.last = 1'b1;
    sev_ok   = (32'(item_r.severity) < NUM_SEVERITIES);
    size     = ent.empty ? '0 : SIZE_W'(SLOT_W'(ent.tail - ent.head)) + SIZE_W'(1);
    rel      = ent.cursor - ent.head;
    avail    = size - SIZE_W'(rel);
    full     = !ent.empty && (ent.tail + SLOT_W'(1) == ent.head);
    res.result_status = STAT_OK;
    if (!sev_ok || item_r.opcode > OP_CLEAR) begin
      res.result_status = STAT_INVALID;
    end else begin
      unique case (item_r.opcode)
        OP_ADD: begin
          wr_need = 1'b1;
          if (full) begin
            if (ent.ovf_total != {OVF_W{1'b1}}) begin
              ent_nxt.ovf_total = ent.ovf_total + OVF_W'(1);
            end
            ent_nxt.ovf_mark  = 1'b1;
            res.result_status = STAT_FULL;
          end else if (ent.empty) begin
            ent_nxt.empty        = 1'b0;
            ent_nxt.head         = '0;
            ent_nxt.tail         = '0;
            ent_nxt.cursor       = '0;
            ent_nxt.cursor_valid = 1'b1;
            pend_nxt[item_r.severity] = 1'b1;
            res.raise_interrupt  = 1'b1;
          end else begin
            ent_nxt.tail   = ent.tail + SLOT_W'(1);
            res.slot_index = ent.tail + SLOT_W'(1);
          end
        end
        OP_GET: begin
          if (size == '0 || !ent.cursor_valid || SIZE_W'(rel) >= size) begin
            res.result_status = STAT_NONE;
          end else begin
            if (avail > SIZE_W'(GET_BATCH)) begin
              n_nxt            = CNT_W'(GET_BATCH);
              res.more_pending = 1'b1;
            end else begin
              n_nxt = CNT_W'(avail);
            end
            wr_need          = 1'b1;
            ent_nxt.cursor   = ent.cursor + SLOT_W'(n_nxt);
            res.slot_index   = ent.cursor;
            res.record_count = n_nxt;
            res.last         = (n_nxt == CNT_W'(1));
            multi            = (n_nxt != CNT_W'(1));
          end
        end
        default: begin
          if (!item_r.clear_all && (item_r.clear_count == '0 ||
              item_r.clear_count > CLR_W'(size))) begin
            res.result_status = STAT_INVALID;
          end else begin
            wr_need = 1'b1;
            if (item_r.clear_all || item_r.clear_count == CLR_W'(size)) begin
              ent_nxt.empty        = 1'b1;
              ent_nxt.head         = '0;
              ent_nxt.tail         = '0;
              ent_nxt.cursor       = '0;
              ent_nxt.cursor_valid = 1'b0;
              pend_nxt[item_r.severity] = 1'b0;
            end else begin
              ent_nxt.head = ent.head + item_r.clear_count[SLOT_W-1:0];
            end
          end
        end
      endcase
    end
    if (sev_ok) begin
      res.overflow_seen  = ent_nxt.ovf_mark;
      res.overflow_count = ent_nxt.ovf_total;
    end
    res.pending_mask = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res;
            pend_r      <= pend_nxt;
            if (multi) begin
              cur_slot_r <= ent.cursor + SLOT_W'(1);
              k_r        <= CNT_W'(1);
              n_r        <= n_nxt;
              state_r    <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r           <= 1'b1;
            out_data_r.slot_index <= cur_slot_r;
            out_data_r.last       <= emit_last;
            cur_slot_r            <= cur_slot_r + SLOT_W'(1);
            k_r                   <= k_r + CNT_W'(1);
            if (emit_last) begin
              state_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  // item accepted -> state read issued in the same cycle, S_RD entered next cycle
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_RD)
    else $error("accepted beat not followed by state read");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> state_r == S_EXEC && slot_free)
    else $error("state write outside execute");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> k_r < n_r && n_r > CNT_W'(1))
    else $error("get beat counter out of range");

  a_multi_is_get: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.record_count > CNT_W'(1))
    else $error("non-final beat outside a multi-slot get");

endmodule
